// ----- src/rlsa_pkg.sv -----
// Shared types, constants and the nibble encoder of the RGB lamp step animator.
// Depends on nothing; every other file of the block but rlsa_ram imports it.
package rlsa_pkg;

   localparam int LAMPS  = 24;
   localparam int STEPS  = 8;
   localparam int DEPTH  = STEPS * LAMPS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PHYS_W = (LAMPS > 1) ? $clog2(LAMPS) : 1;
   localparam int STEP_W = $clog2(STEPS);
   localparam int LOOP_N = (LAMPS > STEPS) ? LAMPS : STEPS;
   localparam int CNT_W  = $clog2(LOOP_N);
   localparam int COLOUR_W = 24;

   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_MASK  = 3'd1;
   localparam logic [2:0] OP_STEP  = 3'd2;
   localparam logic [2:0] OP_CLEAR = 3'd3;
   localparam logic [2:0] OP_SHIFT = 3'd4;

   localparam logic [2:0] CODE_ONE  = 3'b110;
   localparam logic [2:0] CODE_ZERO = 3'b100;

   typedef struct packed {
      logic [2:0] operation;
      logic [4:0] lamp_index;
      logic [2:0] step_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] blink_mask;
   } req_type;

   typedef struct packed {
      logic [4:0]  lamp_number;
      logic [11:0] word_green_high;
      logic [11:0] word_green_low;
      logic [11:0] word_red_high;
      logic [11:0] word_red_low;
      logic [11:0] word_blue_high;
      logic [11:0] word_blue_low;
      logic        last_lamp;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_MASK,
      S_READ,
      S_WAIT,
      S_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic wr_one;
      logic wr_mask;
      logic clr_all;
      logic shift;
      logic adv_step;
      logic cnt_clr;
      logic cnt_inc;
      logic rd_en;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [2:0] op;
      logic       lamp_ok;
      logic       step_ok;
      logic       cnt_last_step;
      logic       cnt_last_lamp;
   } status_type;

   // Each nibble bit, most significant first, becomes a three-bit line code.
   function automatic logic [11:0] encode_nibble(input logic [3:0] nib);
      logic [11:0] w;
      w = '0;
      for (int b = 3; b >= 0; b--) begin
         w = {w[8:0], nib[b] ? CODE_ONE : CODE_ZERO};
      end
      return w;
   endfunction

endpackage

// ----- src/rgb_led_step_animator_top.sv -----
// Top level of the RGB lamp step animator: controller plus datapath.
// Depends on rlsa_pkg, rlsa_ctrl, rlsa_dpath and rlsa_ram.
//
// Usage: one request transaction on req_ carries an operation and its
// operands. Set-with-mask writes one entry per step (one store write per
// cycle); set-one-step, clear-all and shift-up finish in the decode state,
// since clear and shift only touch the entry valid bits and the lamp
// rotation base. A tick advances the step counter and then plays out the
// new step's frame as LAMPS response transactions on rsp_, lamp 0 first,
// with last_lamp set on the final one. Each lamp goes through store read,
// encode into the output register and handshake in turn, driven by the
// sequencer, which handles one lamp at a time without overlapping these
// phases. The first response is valid once the request has passed the
// decode, read and wait states.
// One request is handled at a time: req_stall stays high until all of its
// responses have been taken. A stalled response holds in the output register
// while rsp_stall is high. Synchronous reset marks every store entry dark,
// zeroes the step counter and drops any transaction in progress; no clearing
// pass is needed afterwards.
module rgb_led_step_animator_top
   import rlsa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   cmd_type    cmd;
   status_type status;

   // The sequencer decides what happens in each cycle of a transaction.
   rlsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the frame store and forms the encoded words.
   rlsa_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- src/rlsa_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module rlsa_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/rlsa_ctrl.sv -----
// Controller state machine of the lamp step animator.
// Depends on rlsa_pkg; drives the datapath through cmd_type.
module rlsa_ctrl
   import rlsa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (status.op)
               OP_TICK: state_in = S_READ;
               OP_MASK: state_in = status.lamp_ok ? S_MASK : S_IDLE;
               default: state_in = S_IDLE;
            endcase
         end
         S_MASK: begin
            if (status.cnt_last_step) state_in = S_IDLE;
         end
         S_READ:  state_in = S_WAIT;
         S_WAIT:  state_in = S_OUT;
         S_OUT: begin
            if (!rsp_stall) state_in = status.cnt_last_lamp ? S_IDLE : S_READ;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_OUT);
      case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
         end
         S_DECODE: begin
            case (status.op)
               OP_TICK: begin
                  cmd.adv_step = 1'b1;
                  cmd.cnt_clr  = 1'b1;
               end
               OP_MASK:  cmd.cnt_clr  = 1'b1;
               OP_STEP:  cmd.wr_one   = status.lamp_ok & status.step_ok;
               OP_CLEAR: cmd.clr_all  = 1'b1;
               OP_SHIFT: cmd.shift    = 1'b1;
               default: ;
            endcase
         end
         S_MASK: begin
            cmd.wr_mask = 1'b1;
            cmd.cnt_inc = 1'b1;
         end
         S_READ:  cmd.rd_en    = 1'b1;
         S_WAIT:  cmd.load_out = 1'b1;
         S_OUT: begin
            cmd.cnt_inc = ~rsp_stall & ~status.cnt_last_lamp;
         end
         default: ;
      endcase
   end

endmodule

// ----- src/rlsa_dpath.sv -----
// Datapath of the lamp step animator: request register, frame store with entry
// valid bits, lamp rotation base, step and loop counters, encoder and output register.
// Depends on rlsa_pkg and rlsa_ram.
module rlsa_dpath
   import rlsa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_payload,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_payload
);

   req_type               req_ff;
   rsp_type               rsp_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [PHYS_W-1:0]     base_ff;
   logic [PHYS_W-1:0]     base_in;
   logic [LAMPS-1:0]      valid_ff [STEPS];
   logic                  rd_valid_ff;

   logic [PHYS_W-1:0]     wr_phys;
   logic [PHYS_W-1:0]     rd_phys;
   logic [STEP_W-1:0]     wr_step;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ADDR_W-1:0]     rd_addr;
   logic [COLOUR_W-1:0]   wr_data;
   logic [COLOUR_W-1:0]   rd_data;
   logic [COLOUR_W-1:0]   entry;
   logic                  wr_en;
   logic                  mask_bit;

   // Logical lamp l lives in physical slot (l + base) mod LAMPS.
   function automatic logic [PHYS_W-1:0] phys_of(input logic [PHYS_W:0] lamp,
                                                 input logic [PHYS_W-1:0] base);
      logic [PHYS_W+1:0] sum;
      sum = (PHYS_W+2)'(lamp) + (PHYS_W+2)'(base);
      if (sum >= (PHYS_W+2)'(LAMPS)) sum = sum - (PHYS_W+2)'(LAMPS);
      return sum[PHYS_W-1:0];
   endfunction

   assign wr_phys  = phys_of((PHYS_W+1)'(req_ff.lamp_index), base_ff);
   assign rd_phys  = phys_of((PHYS_W+1)'(cnt_ff), base_ff);
   assign wr_step  = cmd.wr_mask ? cnt_ff[STEP_W-1:0] : req_ff.step_index[STEP_W-1:0];
   assign mask_bit = req_ff.blink_mask[3'(3'd7 - 3'(cnt_ff))];
   assign wr_en    = cmd.wr_one | cmd.wr_mask;
   assign wr_data  = (cmd.wr_one | mask_bit) ? {req_ff.green, req_ff.red, req_ff.blue} : '0;
   assign wr_addr  = ADDR_W'(wr_step) * ADDR_W'(LAMPS) + ADDR_W'(wr_phys);
   assign rd_addr  = ADDR_W'(step_ff) * ADDR_W'(LAMPS) + ADDR_W'(rd_phys);
   assign base_in  = (base_ff == '0) ? PHYS_W'(LAMPS - 1) : base_ff - PHYS_W'(1);

   rlsa_ram #(
      .WIDTH (COLOUR_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         step_ff  <= '0;
         base_ff  <= '0;
         for (int s = 0; s < STEPS; s++) valid_ff[s] <= '0;
      end else begin
         if (cmd.cnt_clr) begin
            cnt_ff <= '0;
         end else if (cmd.cnt_inc) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (cmd.adv_step) begin
            step_ff <= (step_ff == STEP_W'(STEPS - 1)) ? '0 : step_ff + STEP_W'(1);
         end
         if (cmd.clr_all) begin
            for (int s = 0; s < STEPS; s++) valid_ff[s] <= '0;
         end else if (cmd.shift) begin
            // The slot of the dropped top lamp becomes the new dark lamp 0.
            base_ff <= base_in;
            for (int s = 0; s < STEPS; s++) valid_ff[s][base_in] <= 1'b0;
         end else if (wr_en) begin
            valid_ff[wr_step][wr_phys] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      if (cmd.rd_en) begin
         rd_valid_ff <= valid_ff[step_ff][rd_phys];
      end
      if (cmd.load_out) begin
         rsp_ff.lamp_number     <= 5'(cnt_ff);
         rsp_ff.word_green_high <= encode_nibble(entry[23:20]);
         rsp_ff.word_green_low  <= encode_nibble(entry[19:16]);
         rsp_ff.word_red_high   <= encode_nibble(entry[15:12]);
         rsp_ff.word_red_low    <= encode_nibble(entry[11:8]);
         rsp_ff.word_blue_high  <= encode_nibble(entry[7:4]);
         rsp_ff.word_blue_low   <= encode_nibble(entry[3:0]);
         rsp_ff.last_lamp       <= (cnt_ff == CNT_W'(LAMPS - 1));
      end
   end

   assign entry = rd_valid_ff ? rd_data : '0;

   assign status.op            = req_ff.operation;
   assign status.lamp_ok       = (32'(req_ff.lamp_index) < LAMPS);
   assign status.step_ok       = (32'(req_ff.step_index) < STEPS);
   assign status.cnt_last_step = (cnt_ff == CNT_W'(STEPS - 1));
   assign status.cnt_last_lamp = (cnt_ff == CNT_W'(LAMPS - 1));

   assign rsp_payload = rsp_ff;

endmodule

// ----- src/rlsa_checker.sv -----
// Port-level checks of the lamp step animator, bound to the top level.
// Depends on rlsa_pkg and rgb_led_step_animator_top.
module rlsa_checker
   import rlsa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // No new request is taken while a response waits.
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while response pending");

   // After a lamp other than the last, the frame continues.
   a_mid_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.last_lamp |=> req_stall)
      else $error("block went idle mid frame");

   // The last-lamp flag marks exactly the top lamp.
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.last_lamp == (32'(rsp_payload.lamp_number) == LAMPS - 1)))
      else $error("last_lamp flag mismatch");

   // Reset drops any response.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind rgb_led_step_animator_top rlsa_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
